FILE: hw/rtl/msp_pkg.sv
// shared types, codes and reply tables for the msp request responder
package msp_pkg;

    // result kinds carried on the output tuser
    localparam logic [2:0] ST_REPLY   = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_BADSUM  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_VARIANT = 3'd0;
    localparam logic [2:0] CFG_UID0    = 3'd1;
    localparam logic [2:0] CFG_UID1    = 3'd2;
    localparam logic [2:0] CFG_UID2    = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT = 3'd4;

    // configuration reset values
    localparam logic [31:0] RST_VARIANT = 32'h5155_4943;
    localparam logic [31:0] RST_UID0    = 32'h0000_0000;
    localparam logic [31:0] RST_UID1    = 32'h0D0E_0A0D;
    localparam logic [31:0] RST_UID2    = 32'h0B0E_0E0F;
    localparam logic [15:0] RST_TIMEOUT = 16'd1000;

    // frame characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;

    // request codes
    localparam logic [7:0] CODE_API     = 8'd1;
    localparam logic [7:0] CODE_VARIANT = 8'd2;
    localparam logic [7:0] CODE_VERSION = 8'd3;
    localparam logic [7:0] CODE_BOARD   = 8'd4;
    localparam logic [7:0] CODE_BUILD   = 8'd5;
    localparam logic [7:0] CODE_UID     = 8'd160;

    localparam logic [7:0] API_MINOR = 8'd41;

    // reply header bytes before the data: $ M > len code
    localparam logic [4:0] HDR_LEN = 5'd5;

    localparam int BUILD_LEN = 19;
    localparam logic [7:0] BUILD_STAMP [BUILD_LEN] = '{
        8'h4A, 8'h61, 8'h6E, 8'h20, 8'h20, 8'h31, 8'h20, 8'h32, 8'h30, 8'h30,
        8'h30, 8'h30, 8'h30, 8'h3A, 8'h30, 8'h30, 8'h3A, 8'h30, 8'h30
    };

    // controller to datapath
    typedef struct packed {
        logic       load_size;
        logic       load_code;
        logic       data_step;
        logic       tick_step;
        logic       start_reply;
        logic       emit_step;
        logic       out_load;
        logic [2:0] out_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_dollar;
        logic is_m;
        logic is_lt;
        logic byte_zero;
        logic size_zero;
        logic count_done;
        logic tick_expire;
        logic xor_match;
        logic code_known;
        logic emit_last;
        logic out_free;
    } t_stat;

    // data length of the reply to a code, zero for codes without a reply
    function automatic logic [4:0] reply_len(input logic [7:0] code);
        logic [4:0] len;
        len = 5'd0;
        case (code)
            CODE_API:     len = 5'd3;
            CODE_VARIANT: len = 5'd4;
            CODE_VERSION: len = 5'd3;
            CODE_BOARD:   len = 5'd6;
            CODE_BUILD:   len = 5'(BUILD_LEN);
            CODE_UID:     len = 5'd12;
            default:      len = 5'd0;
        endcase
        return len;
    endfunction

    // byte k of a word, most significant first
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    // data byte k of the reply to a known code
    function automatic logic [7:0] reply_data(
        input logic [7:0]  code,
        input logic [4:0]  k,
        input logic [31:0] variant,
        input logic [31:0] uid0,
        input logic [31:0] uid1,
        input logic [31:0] uid2
    );
        logic [7:0] b;
        b = 8'd0;
        case (code)
            CODE_API: begin
                if (k == 5'd1) begin
                    b = 8'd1;
                end else if (k == 5'd2) begin
                    b = API_MINOR;
                end
            end
            CODE_VARIANT: begin
                b = word_byte(variant, k[1:0]);
            end
            CODE_VERSION: begin
                if (k == 5'd1) begin
                    b = 8'd1;
                end
            end
            CODE_BOARD: begin
                if (k < 5'd4) begin
                    b = word_byte(variant, k[1:0]);
                end
            end
            CODE_BUILD: begin
                if (k < 5'(BUILD_LEN)) begin
                    b = BUILD_STAMP[k];
                end
            end
            CODE_UID: begin
                case (k[4:2])
                    3'd0:    b = word_byte(uid0, k[1:0]);
                    3'd1:    b = word_byte(uid1, k[1:0]);
                    3'd2:    b = word_byte(uid2, k[1:0]);
                    default: b = 8'd0;
                endcase
            end
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/msp_ctrl.sv
// request parser and reply sequencer state machine
module msp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_command,
    input  msp_pkg::t_stat i_stat,
    output logic           o_ready,
    output msp_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_HUNT = 3'd0;
    localparam logic [2:0] S_M    = 3'd1;
    localparam logic [2:0] S_LT   = 3'd2;
    localparam logic [2:0] S_SIZE = 3'd3;
    localparam logic [2:0] S_CODE = 3'd4;
    localparam logic [2:0] S_DATA = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       acc;

    assign o_ready = (r_state != S_EMIT) && i_stat.out_free;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_status = msp_pkg::ST_REPLY;
        if (r_state == S_EMIT) begin
            if (i_stat.out_free) begin
                o_cmd.out_load  = 1'b1;
                o_cmd.emit_step = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = S_HUNT;
                end
            end
        end else if (acc && i_command) begin
            // ticks only count during the payload
            if (r_state == S_DATA) begin
                o_cmd.tick_step = 1'b1;
                if (i_stat.tick_expire) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = msp_pkg::ST_TIMEOUT;
                    n_state          = S_HUNT;
                end
            end
        end else if (acc) begin
            unique case (r_state)
                S_HUNT: begin
                    if (i_stat.is_dollar) begin
                        n_state = S_M;
                    end
                end
                S_M: begin
                    n_state = i_stat.is_m ? S_LT : S_HUNT;
                end
                S_LT: begin
                    n_state = i_stat.is_lt ? S_SIZE : S_HUNT;
                end
                S_SIZE: begin
                    o_cmd.load_size = 1'b1;
                    n_state         = S_CODE;
                end
                S_CODE: begin
                    o_cmd.load_code = 1'b1;
                    if (i_stat.byte_zero) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = msp_pkg::ST_ZERO;
                        n_state          = S_HUNT;
                    end else begin
                        n_state = i_stat.size_zero ? S_SUM : S_DATA;
                    end
                end
                S_DATA: begin
                    o_cmd.data_step = 1'b1;
                    if (i_stat.count_done) begin
                        n_state = S_SUM;
                    end
                end
                S_SUM: begin
                    if (!i_stat.xor_match) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = msp_pkg::ST_BADSUM;
                        n_state          = S_HUNT;
                    end else if (!i_stat.code_known) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = msp_pkg::ST_UNKNOWN;
                        n_state          = S_HUNT;
                    end else begin
                        o_cmd.start_reply = 1'b1;
                        n_state           = S_EMIT;
                    end
                end
                default: begin
                    n_state = S_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/msp_dpath.sv
// config registers, frame counters, checksum, reply byte generation and output register
module msp_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    input  logic [7:0]     i_rx_byte,
    input  msp_pkg::t_cmd  i_cmd,
    input  logic           i_out_ready,
    output msp_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output logic [7:0]     o_tx_byte,
    output logic [2:0]     o_status,
    output logic           o_last
);

    logic [31:0] r_variant;
    logic [31:0] r_uid0;
    logic [31:0] r_uid1;
    logic [31:0] r_uid2;
    logic [15:0] r_timeout;

    logic [7:0]  r_size;
    logic [7:0]  r_count;
    logic [7:0]  r_code;
    logic [7:0]  r_xor;
    logic [15:0] r_ticks;
    logic [4:0]  r_idx;
    logic [4:0]  r_len;

    logic        r_ovalid;
    logic [7:0]  r_otx;
    logic [2:0]  r_ostatus;
    logic        r_olast;

    logic [8:0]  count_inc;
    logic [4:0]  sum_idx;
    logic [4:0]  data_idx;
    logic        in_data;
    logic [7:0]  data_byte;
    logic [7:0]  frame_byte;
    logic [4:0]  code_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= msp_pkg::RST_VARIANT;
            r_uid0    <= msp_pkg::RST_UID0;
            r_uid1    <= msp_pkg::RST_UID1;
            r_uid2    <= msp_pkg::RST_UID2;
            r_timeout <= msp_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msp_pkg::CFG_VARIANT: r_variant <= i_cfg_data;
                msp_pkg::CFG_UID0:    r_uid0    <= i_cfg_data;
                msp_pkg::CFG_UID1:    r_uid1    <= i_cfg_data;
                msp_pkg::CFG_UID2:    r_uid2    <= i_cfg_data;
                msp_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign count_inc = {1'b0, r_count} + 9'd1;
    assign code_len  = msp_pkg::reply_len(r_code);
    assign sum_idx   = r_len + msp_pkg::HDR_LEN;
    assign data_idx  = r_idx - msp_pkg::HDR_LEN;
    assign in_data   = (r_idx >= msp_pkg::HDR_LEN) && (r_idx < sum_idx);
    assign data_byte = msp_pkg::reply_data(r_code, data_idx, r_variant, r_uid0, r_uid1,
                                           r_uid2);

    always_comb begin
        case (r_idx)
            5'd0:    frame_byte = msp_pkg::CH_DOLLAR;
            5'd1:    frame_byte = msp_pkg::CH_M;
            5'd2:    frame_byte = msp_pkg::CH_GT;
            5'd3:    frame_byte = {3'b000, r_len};
            5'd4:    frame_byte = r_code;
            default: frame_byte = in_data ? data_byte : r_xor;
        endcase
    end

    always_comb begin
        o_stat             = '0;
        o_stat.is_dollar   = (i_rx_byte == msp_pkg::CH_DOLLAR);
        o_stat.is_m        = (i_rx_byte == msp_pkg::CH_M);
        o_stat.is_lt       = (i_rx_byte == msp_pkg::CH_LT);
        o_stat.byte_zero   = (i_rx_byte == 8'd0);
        o_stat.size_zero   = (r_size == 8'd0);
        o_stat.count_done  = (count_inc >= {1'b0, r_size});
        o_stat.tick_expire = (r_ticks <= 16'd1);
        o_stat.xor_match   = (i_rx_byte == r_xor);
        o_stat.code_known  = (code_len != 5'd0);
        o_stat.emit_last   = (r_idx == sum_idx);
        o_stat.out_free    = !r_ovalid || i_out_ready;
    end

    // parse and reply registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_size) begin
            r_size <= i_rx_byte;
        end
        if (i_cmd.load_code) begin
            r_code  <= i_rx_byte;
            r_xor   <= r_size ^ i_rx_byte;
            r_count <= 8'd0;
            r_ticks <= (r_timeout == 16'd0) ? 16'd1 : r_timeout;
        end
        if (i_cmd.data_step) begin
            r_xor   <= r_xor ^ i_rx_byte;
            r_count <= count_inc[7:0];
        end
        if (i_cmd.tick_step && (r_ticks != 16'd0)) begin
            r_ticks <= r_ticks - 16'd1;
        end
        if (i_cmd.start_reply) begin
            r_idx <= 5'd0;
            r_len <= code_len;
            r_xor <= {3'b000, code_len} ^ r_code;
        end
        if (i_cmd.emit_step) begin
            r_idx <= r_idx + 5'd1;
            if (in_data) begin
                r_xor <= r_xor ^ data_byte;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.out_status;
            if (i_cmd.out_status == msp_pkg::ST_REPLY) begin
                r_otx   <= frame_byte;
                r_olast <= (r_idx == sum_idx);
            end else begin
                r_otx   <= 8'd0;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_tx_byte   = r_otx;
    assign o_status    = r_ostatus;
    assign o_last      = r_olast;

endmodule

FILE: hw/rtl/msp_request_responder.sv
// top level of the msp v1 request responder
//
// Takes a stream of items, each either a received byte or a 10 ms tick, hunts
// for a "$M<" request header, reads size, code, payload and checksum, and answers
// with a status item or a "$M>" reply frame of one byte per item. Each input item
// produces at most one item, except a good request with a known code: that one
// stops input while the reply sequencer walks its frame of len + 6 bytes (at most
// 25) through the output register, one byte per cycle while the output is free.
// Status items carry a zero data byte and tlast high; a reply frame raises tlast
// on its checksum byte. Ticks outside the payload are swallowed without an item.
// Configuration writes are taken at any time but should only be made while the
// block is idle.
module msp_request_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,      // 0 variant, 1-3 uid words, 4 timeout
    input  logic [31:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] command: 0 byte, 1 tick
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);

    msp_pkg::t_cmd  cmd;
    msp_pkg::t_stat stat;

    // parser / sequencer: decides what each item does
    msp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_command (s_axis_tuser),
        .i_stat    (stat),
        .o_ready   (s_axis_tready),
        .o_cmd     (cmd)
    );

    // counters, checksum, reply tables and the output register
    msp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (s_axis_tdata),
        .i_cmd       (cmd),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_tx_byte   (m_axis_tdata),
        .o_status    (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule
